>>> rtl/tsc_pkg.sv
// tsc_pkg: shared types, character codes and classifiers for the token scanner
// no dependencies; used through scoped names by every rtl file but tsc_if
package tsc_pkg;

  typedef enum logic [2:0] {
    EV_APPEND  = 3'd0,
    EV_END     = 3'd1,
    EV_SPECIAL = 3'd2,
    EV_ERROR   = 3'd3,
    EV_DONE    = 3'd4
  } event_kind_e;

  typedef enum logic [1:0] {
    CM_NONE  = 2'd0,
    CM_LINE  = 2'd1,
    CM_BLOCK = 2'd2,
    CM_STAR  = 2'd3
  } comment_mode_e;

  typedef struct packed {
    comment_mode_e cm;
    logic          iq;
    logic          dn;
    logic          sp;
    logic          tk;
  } flags_t;

  localparam flags_t FLAGS_RST = '{cm: CM_NONE, iq: 1'b0, dn: 1'b0, sp: 1'b0, tk: 1'b0};

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] col;
  } ev_t;

  localparam int unsigned MAX_EV = 4;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  function automatic logic is_special(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI,
      CH_COLON, CH_LT, CH_GT, CH_EQ, CH_DOT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_SPACE, CH_NL, CH_TAB: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/tsc_if.sv
// tsc_in_if, tsc_out_if: valid/ready channels for source bytes and token events
// no dependencies
interface tsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface tsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  char_out;
  logic [15:0] line_no;
  logic [15:0] column_no;
  logic        run_last;

  modport source (output valid, output event_kind, output char_out, output line_no,
                  output column_no, output run_last, input ready);
  modport sink   (input valid, input event_kind, input char_out, input line_no,
                  input column_no, input run_last, output ready);
endinterface

>>> rtl/tsc_step.sv
// tsc_step: combinational scan of one byte against the scanner state
// depends on tsc_pkg; gives next state and up to four events
module tsc_step #(
  parameter int unsigned LW = 16,
  parameter int unsigned CW = 16
) (
  input  logic [7:0]             char_i,
  input  logic                   eoi_i,
  input  tsc_pkg::flags_t        flags_i,
  input  logic [LW-1:0]          line_i,
  input  logic [CW-1:0]          col_i,
  output tsc_pkg::flags_t        flags_o,
  output logic [LW-1:0]          line_o,
  output logic [CW-1:0]          col_o,
  output tsc_pkg::ev_t [3:0]     evs_o,
  output logic [2:0]             cnt_o
);

  localparam logic [LW-1:0] LnMax = '1;
  localparam logic [CW-1:0] ColMax = '1;
  localparam logic [2:0]    EvCap = 3'(tsc_pkg::MAX_EV);

  tsc_pkg::flags_t    f;
  logic [LW-1:0]      ln;
  logic [CW-1:0]      col;
  logic [2:0]         n;
  tsc_pkg::ev_t [3:0] ev;
  logic               c_plain;

  always_comb begin
    f       = flags_i;
    ln      = line_i;
    col     = col_i;
    n       = 3'd0;
    ev      = '0;
    c_plain = 1'b0;

    unique case (f.cm)
      tsc_pkg::CM_LINE: begin
        if (char_i == tsc_pkg::CH_NL) begin
          if (ln != LnMax) ln = ln + LW'(1);
          col  = CW'(1);
          f.cm = tsc_pkg::CM_NONE;
        end else begin
          if (col != ColMax) col = col + CW'(1);
        end
      end
      tsc_pkg::CM_BLOCK: begin
        if (char_i == tsc_pkg::CH_NL) begin
          if (ln != LnMax) ln = ln + LW'(1);
          col = CW'(1);
        end else begin
          if (char_i == tsc_pkg::CH_STAR) f.cm = tsc_pkg::CM_STAR;
          if (col != ColMax) col = col + CW'(1);
        end
      end
      tsc_pkg::CM_STAR: begin
        if (char_i == tsc_pkg::CH_NL) begin
          if (ln != LnMax) ln = ln + LW'(1);
          col  = CW'(1);
          f.cm = tsc_pkg::CM_BLOCK;
        end else begin
          if (char_i == tsc_pkg::CH_SLASH) f.cm = tsc_pkg::CM_NONE;
          else if (char_i != tsc_pkg::CH_STAR) f.cm = tsc_pkg::CM_BLOCK;
          if (col != ColMax) col = col + CW'(1);
        end
      end
      tsc_pkg::CM_NONE: begin
        c_plain = 1'b1;
        if (f.sp) begin
          f.sp = 1'b0;
          if (char_i == tsc_pkg::CH_SLASH || char_i == tsc_pkg::CH_STAR) begin
            if (col != ColMax) col = col + CW'(1);
            if (col != ColMax) col = col + CW'(1);
            f.cm    = (char_i == tsc_pkg::CH_SLASH) ? tsc_pkg::CM_LINE : tsc_pkg::CM_BLOCK;
            c_plain = 1'b0;
          end else begin
            // held slash as a plain character
            if (f.dn) begin
              f.dn = 1'b0;
            end else begin
              if (n != EvCap) begin
                ev[n[1:0]] = '{kind: tsc_pkg::EV_APPEND, ch: tsc_pkg::CH_SLASH,
                               line: 16'(ln), col: 16'(col)};
                n = n + 3'd1;
              end
              f.tk = 1'b1;
            end
            if (col != ColMax) col = col + CW'(1);
          end
        end
        if (c_plain && !f.iq && char_i == tsc_pkg::CH_SLASH && !eoi_i) begin
          f.sp    = 1'b1;
          c_plain = 1'b0;
        end
        if (c_plain) begin
          if (char_i == tsc_pkg::CH_BSLASH) begin
            f.dn = 1'b1;
            if (col != ColMax) col = col + CW'(1);
          end else if (f.dn) begin
            f.dn = 1'b0;
            if (col != ColMax) col = col + CW'(1);
          end else if (char_i == tsc_pkg::CH_QUOTE) begin
            if (f.iq) begin
              f.iq = 1'b0;
              if (f.tk) begin
                if (n != EvCap) begin
                  ev[n[1:0]] = '{kind: tsc_pkg::EV_END, ch: 8'h00,
                                 line: 16'(ln), col: 16'(col)};
                  n = n + 3'd1;
                end
                f.tk = 1'b0;
              end
            end else begin
              f.iq = 1'b1;
            end
            if (col != ColMax) col = col + CW'(1);
          end else if (!f.iq && (tsc_pkg::is_break(char_i) ||
                                 tsc_pkg::is_special(char_i))) begin
            if (f.tk) begin
              if (n != EvCap) begin
                ev[n[1:0]] = '{kind: tsc_pkg::EV_END, ch: 8'h00,
                               line: 16'(ln), col: 16'(col)};
                n = n + 3'd1;
              end
              f.tk = 1'b0;
            end
            if (tsc_pkg::is_special(char_i) && n != EvCap) begin
              ev[n[1:0]] = '{kind: tsc_pkg::EV_SPECIAL, ch: char_i,
                             line: 16'(ln), col: 16'(col)};
              n = n + 3'd1;
            end
            if (char_i == tsc_pkg::CH_NL) begin
              if (ln != LnMax) ln = ln + LW'(1);
              col = CW'(1);
            end else begin
              if (col != ColMax) col = col + CW'(1);
            end
          end else begin
            if (n != EvCap) begin
              ev[n[1:0]] = '{kind: tsc_pkg::EV_APPEND, ch: char_i,
                             line: 16'(ln), col: 16'(col)};
              n = n + 3'd1;
            end
            f.tk = 1'b1;
            if (col != ColMax) col = col + CW'(1);
          end
        end
      end
    endcase

    // final byte closes the text
    if (eoi_i) begin
      if (f.cm == tsc_pkg::CM_BLOCK || f.cm == tsc_pkg::CM_STAR) begin
        if (n != EvCap) begin
          ev[n[1:0]] = '{kind: tsc_pkg::EV_ERROR, ch: 8'h00, line: 16'(ln), col: 16'(col)};
          n = n + 3'd1;
        end
      end else if (f.tk) begin
        if (n != EvCap) begin
          ev[n[1:0]] = '{kind: tsc_pkg::EV_END, ch: 8'h00, line: 16'(ln), col: 16'(col)};
          n = n + 3'd1;
        end
      end
      if (n != EvCap) begin
        ev[n[1:0]] = '{kind: tsc_pkg::EV_DONE, ch: 8'h00, line: 16'(ln), col: 16'(col)};
        n = n + 3'd1;
      end
      f   = tsc_pkg::FLAGS_RST;
      ln  = LW'(1);
      col = CW'(1);
    end
  end

  assign flags_o = f;
  assign line_o  = ln;
  assign col_o   = col;
  assign evs_o   = ev;
  assign cnt_o   = n;

endmodule

>>> rtl/tsc_evbuf.sv
// tsc_evbuf: result register holding the events of one byte, drained one per cycle while out_o.ready is high
// depends on tsc_pkg and tsc_out_if
module tsc_evbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tsc_pkg::ev_t [3:0] evs_i,
  input  logic [2:0]         cnt_i,
  output logic               free_o,
  tsc_out_if.source          out_o
);

  tsc_pkg::ev_t [3:0] ev_q;
  logic [2:0]         cnt_q;
  logic [1:0]         rd_q;
  logic               take;
  logic               take_last;
  logic               at_last;

  assign at_last   = ({1'b0, rd_q} + 3'd1) == cnt_q;
  assign take      = out_o.valid && out_o.ready;
  assign take_last = take && at_last;
  assign free_o    = (cnt_q == 3'd0) || take_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      rd_q  <= 2'd0;
    end else if (load_i) begin
      cnt_q <= cnt_i;
      rd_q  <= 2'd0;
    end else if (take_last) begin
      cnt_q <= 3'd0;
      rd_q  <= 2'd0;
    end else if (take) begin
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) ev_q <= evs_i;
  end

  assign out_o.valid      = cnt_q != 3'd0;
  assign out_o.event_kind = ev_q[rd_q].kind;
  assign out_o.char_out   = ev_q[rd_q].ch;
  assign out_o.line_no    = ev_q[rd_q].line;
  assign out_o.column_no  = ev_q[rd_q].col;
  assign out_o.run_last   = at_last;

endmodule

>>> rtl/token_scanner_with_comments.sv
// token_scanner_with_comments: streaming c-style scanner, bytes in, token events out
// depends on tsc_pkg, tsc_if, tsc_step, tsc_evbuf
//
//   channel  dir  payload                                          item
//   in_i     in   char_in[7:0] end_of_input                        one source byte
//   out_o    out  event_kind[2:0] char_out[7:0] line_no[15:0]      one token event
//                 column_no[15:0] run_last
//
// a byte passes an input register, is scanned combinationally and its events
// land in the result register, which drains one event per cycle on out_o.ready;
// the next byte loads when that register is empty or its last event is taken, so
// with out_o.ready high, bytes with no or one event stream at one per cycle
// reset: no comment, no quotes, empty token, line 1 column 1; same after the final byte
// output stalls back up into the input register, then to in_i.ready
module token_scanner_with_comments #(
  parameter int unsigned LINE_WIDTH   = 16,
  parameter int unsigned COLUMN_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsc_in_if.sink    in_i,
  tsc_out_if.source out_o
);

  logic                    in_vld_q;
  logic [7:0]              char_q;
  logic                    eoi_q;
  tsc_pkg::flags_t         flags_q, flags_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d;
  tsc_pkg::ev_t [3:0]      evs;
  logic [2:0]              ev_cnt;
  logic                    buf_free;
  logic                    move;

  assign move       = in_vld_q && buf_free;
  assign in_i.ready = !in_vld_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      flags_q  <= tsc_pkg::FLAGS_RST;
      line_q   <= LINE_WIDTH'(1);
      col_q    <= COLUMN_WIDTH'(1);
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (move) begin
        flags_q <= flags_d;
        line_q  <= line_d;
        col_q   <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_in;
      eoi_q  <= in_i.end_of_input;
    end
  end

  tsc_step #(
    .LW (LINE_WIDTH),
    .CW (COLUMN_WIDTH)
  ) u_step (
    .char_i  (char_q),
    .eoi_i   (eoi_q),
    .flags_i (flags_q),
    .line_i  (line_q),
    .col_i   (col_q),
    .flags_o (flags_d),
    .line_o  (line_d),
    .col_o   (col_d),
    .evs_o   (evs),
    .cnt_o   (ev_cnt)
  );

  tsc_evbuf u_evbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (move),
    .evs_i  (evs),
    .cnt_i  (ev_cnt),
    .free_o (buf_free),
    .out_o  (out_o)
  );

endmodule

>>> rtl/tsc_checker.sv
// tsc_checker: port-level checks on the event channel of the token scanner
// depends on tsc_pkg; bound to token_scanner_with_comments below
module tsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  event_kind_i,
  input logic [7:0]  char_out_i,
  input logic [15:0] line_no_i,
  input logic [15:0] column_no_i,
  input logic        run_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i) &&
      $stable(char_out_i) && $stable(line_no_i) && $stable(column_no_i) &&
      $stable(run_last_i))
    else $error("stalled event changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == tsc_pkg::EV_DONE |-> run_last_i)
    else $error("done event not last of its byte");

  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == tsc_pkg::EV_END || event_kind_i == tsc_pkg::EV_ERROR ||
      event_kind_i == tsc_pkg::EV_DONE) |-> char_out_i == 8'h00)
    else $error("character on a control event");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> line_no_i != 16'd0 && column_no_i != 16'd0)
    else $error("position wrapped to zero");

endmodule

bind token_scanner_with_comments tsc_checker u_tsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_kind_i (out_o.event_kind),
  .char_out_i   (out_o.char_out),
  .line_no_i    (out_o.line_no),
  .column_no_i  (out_o.column_no),
  .run_last_i   (out_o.run_last)
);
